// ----- rtl/tpdd_pkg.sv -----
// Shared types and constants for the tap position debounce and decode block.
// No dependencies; imported by every module of the block.
package tpdd_pkg;

    localparam int NUM_LINES     = 13;
    localparam int NUM_POS_LINES = 8;
    localparam int CNT_W         = 16;
    localparam int TAP_W         = 5;
    localparam int FLAG_W        = 17;
    localparam int LINE_IDX_W    = 4;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 4;
    localparam int SP_W          = 5;
    localparam int FAULT_CNT_W   = 8;

    // Bit positions within the debounced line vector.
    localparam int LN_PARITY_A    = 8;
    localparam int LN_PARITY_B    = 9;
    localparam int LN_POLARITY    = 10;
    localparam int LN_MOTOR_SEL   = 11;
    localparam int LN_SOLENOID    = 12;
    localparam int NUM_CONTACTS   = 11;

    localparam logic [TAP_W-1:0]       CENTER_POS     = 5'd9;
    localparam logic [FAULT_CNT_W-1:0] LOCKOUT_LIMIT  = 8'd2;
    localparam logic [CNT_W-1:0]       TICKS_RESET    = 16'd10;
    localparam logic [CNT_W-1:0]       CNT_RESET      = 16'd1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SEVERAL = 2'd2;

    typedef struct packed {
        logic [TAP_W-1:0]      tap;
        logic [STATUS_W-1:0]   status;
        logic [FLAG_W-1:0]     flags;
        logic [LINE_IDX_W-1:0] line_k;
        logic                  ok;
    } t_decode;

endpackage

// ----- rtl/tpdd_debounce.sv -----
// Per-line debounce counters and the debounced contact lines.
// Depends on tpdd_pkg.
module tpdd_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [tpdd_pkg::NUM_LINES-1:0] i_raw,
    input  logic [tpdd_pkg::CNT_W-1:0]     i_ticks,
    output logic [tpdd_pkg::NUM_LINES-1:0] o_lines
);
    import tpdd_pkg::*;

    logic [CNT_W-1:0]     r_cnt [NUM_LINES];
    logic [CNT_W-1:0]     n_cnt [NUM_LINES];
    logic [NUM_LINES-1:0] r_lines;
    logic [NUM_LINES-1:0] n_lines;

    // Pins are active low, so a pin equal to its debounced bit disagrees with it.
    always_comb begin
        for (int i = 0; i < NUM_LINES; i++) begin
            n_cnt[i]   = r_cnt[i];
            n_lines[i] = r_lines[i];
            if (i_raw[i] == r_lines[i]) begin
                if (r_cnt[i] < i_ticks) begin
                    n_cnt[i] = r_cnt[i] + CNT_W'(1);
                end else begin
                    n_lines[i] = ~i_raw[i];
                end
            end else begin
                n_cnt[i] = '0;
            end
        end
    end

    assign o_lines = n_lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                r_cnt[i] <= CNT_RESET;
            end
            r_lines <= '0;
        end else if (i_step) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
            r_lines <= n_lines;
        end
    end

endmodule

// ----- rtl/tpdd_decode.sv -----
// Decodes debounced position, parity and polarity lines into a tap position.
// Depends on tpdd_pkg.
module tpdd_decode #(
    parameter int NUM_POSITIONS = 17
) (
    input  logic [tpdd_pkg::NUM_CONTACTS-1:0] i_lines,
    output tpdd_pkg::t_decode                 o_dec
);
    import tpdd_pkg::*;

    logic [COUNT_W-1:0]    count;
    logic [LINE_IDX_W-1:0] k;
    logic [LINE_IDX_W-1:0] m;
    logic                  pa;
    logic                  pb;
    logic                  pol;
    logic [TAP_W-1:0]      tap;
    logic                  ok;

    assign pa  = i_lines[LN_PARITY_A];
    assign pb  = i_lines[LN_PARITY_B];
    assign pol = i_lines[LN_POLARITY];

    always_comb begin
        count = '0;
        k     = '0;
        for (int i = 0; i < NUM_POS_LINES; i++) begin
            if (i_lines[i]) begin
                count = count + COUNT_W'(1);
                k     = LINE_IDX_W'(i + 1);
            end
        end
    end

    // Parity A rounds the line index down to even, parity B down to odd.
    always_comb begin
        if (pa) begin
            m = {k[LINE_IDX_W-1:1], 1'b0};
        end else if (!k[0]) begin
            m = k - LINE_IDX_W'(1);
        end else begin
            m = k;
        end
        tap = pol ? (CENTER_POS + {1'b0, m}) : (CENTER_POS - {1'b0, m});
    end

    assign ok = (count == COUNT_W'(1)) && (pa != pb);

    always_comb begin
        o_dec        = '0;
        o_dec.ok     = ok;
        o_dec.line_k = k;
        if (ok) begin
            o_dec.status = ST_OK;
            o_dec.tap    = tap;
            for (int i = 0; i < FLAG_W; i++) begin
                if (i < NUM_POSITIONS && tap == TAP_W'(i + 1)) begin
                    o_dec.flags[i] = 1'b1;
                end
            end
        end else begin
            if (count == '0 || (count == COUNT_W'(1) && !pa && !pb)) begin
                o_dec.status = ST_NONE;
            end else begin
                o_dec.status = ST_SEVERAL;
            end
            o_dec.flags = FLAG_W'(i_lines);
        end
    end

endmodule

// ----- rtl/tpdd_fault.sv -----
// Fault map per stored position, last decoded line index and the check flag.
// Depends on tpdd_pkg.
module tpdd_fault #(
    parameter int NUM_POSITIONS = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_lock,
    input  logic                            i_ok,
    input  logic [tpdd_pkg::LINE_IDX_W-1:0] i_line_k,
    input  logic [tpdd_pkg::SP_W-1:0]       i_stored_position,
    output logic [tpdd_pkg::LINE_IDX_W-1:0] o_selected_line,
    output logic                            o_check
);
    import tpdd_pkg::*;

    localparam int MAP_W = NUM_POSITIONS + 1;

    logic [MAP_W-1:0]      r_map;
    logic [MAP_W-1:0]      n_map;
    logic [LINE_IDX_W-1:0] r_last;
    logic [LINE_IDX_W-1:0] n_last;

    // During lockout the map and the line index are frozen.
    always_comb begin
        n_map  = r_map;
        n_last = r_last;
        if (!i_lock) begin
            if (i_ok) begin
                n_last = i_line_k;
            end
            for (int j = 0; j < MAP_W; j++) begin
                if (i_stored_position == SP_W'(j)) begin
                    n_map[j] = ~i_ok;
                end
            end
        end
    end

    // Mark zero is stored but never counts as a fault.
    assign o_check         = i_lock || (|n_map[MAP_W-1:1]);
    assign o_selected_line = n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '0;
            r_last <= '0;
        end else if (i_step) begin
            r_map  <= n_map;
            r_last <= n_last;
        end
    end

endmodule

// ----- rtl/tap_position_debounce_decode.sv -----
// Tap position debounce and decode, top level.
// An accepted input transaction passes the input register, then the result register.
// One transaction per cycle unless the result side stalls; the debounce counters and
// fault map update in the cycle an item moves from the input to the result register.
// Reset (synchronous, active low) clears both registers' valid flags, sets every
// counter to one, the debounce time to 10 ticks, and clears lines, fault map and line index.
module tap_position_debounce_decode #(
    parameter int NUM_POSITIONS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_raw_position_lines,
    input  logic        i_raw_parity_a,
    input  logic        i_raw_parity_b,
    input  logic        i_raw_polarity,
    input  logic        i_raw_motor_select,
    input  logic        i_raw_solenoid,
    input  logic [4:0]  i_stored_position,
    input  logic [7:0]  i_solenoid_fault_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_tap_position,
    output logic [1:0]  o_position_status,
    output logic [16:0] o_position_flags,
    output logic [3:0]  o_selected_line,
    output logic        o_motor_select_seen,
    output logic        o_solenoid_seen,
    output logic        o_check_status
);
    import tpdd_pkg::*;

    logic [CNT_W-1:0]       r_ticks;
    logic                   r_s1_valid;
    logic [NUM_LINES-1:0]   r_raw;
    logic [SP_W-1:0]        r_sp;
    logic [FAULT_CNT_W-1:0] r_sfc;

    logic                   advance;
    logic                   step;
    logic                   in_take;
    logic                   lock;
    logic [NUM_LINES-1:0]   lines;
    t_decode                dec;
    logic [LINE_IDX_W-1:0]  sel_line;
    logic                   check;

    logic                   r_out_valid;
    logic [TAP_W-1:0]       r_tap;
    logic [STATUS_W-1:0]    r_status;
    logic [FLAG_W-1:0]      r_flags;
    logic [LINE_IDX_W-1:0]  r_sel;
    logic                   r_ms;
    logic                   r_sol;
    logic                   r_chk;

    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign lock       = r_sfc > LOCKOUT_LIMIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RESET;
        end else if (i_cfg_we) begin
            r_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw <= {i_raw_solenoid, i_raw_motor_select, i_raw_polarity,
                      i_raw_parity_b, i_raw_parity_a, i_raw_position_lines};
            r_sp  <= i_stored_position;
            r_sfc <= i_solenoid_fault_count;
        end
    end

    tpdd_debounce u_debounce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_raw   (r_raw),
        .i_ticks (r_ticks),
        .o_lines (lines)
    );

    tpdd_decode #(
        .NUM_POSITIONS (NUM_POSITIONS)
    ) u_decode (
        .i_lines (lines[NUM_CONTACTS-1:0]),
        .o_dec   (dec)
    );

    tpdd_fault #(
        .NUM_POSITIONS (NUM_POSITIONS)
    ) u_fault (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_lock            (lock),
        .i_ok              (dec.ok),
        .i_line_k          (dec.line_k),
        .i_stored_position (r_sp),
        .o_selected_line   (sel_line),
        .o_check           (check)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_tap    <= dec.tap;
            r_status <= dec.status;
            r_flags  <= dec.flags;
            r_sel    <= sel_line;
            r_ms     <= lines[LN_MOTOR_SEL];
            r_sol    <= lines[LN_SOLENOID];
            r_chk    <= check;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_tap_position      = r_tap;
    assign o_position_status   = r_status;
    assign o_position_flags    = r_flags;
    assign o_selected_line     = r_sel;
    assign o_motor_select_seen = r_ms;
    assign o_solenoid_seen     = r_sol;
    assign o_check_status      = r_chk;

endmodule

// ----- rtl/tpdd_checker.sv -----
// Port-level checks for the tap position debounce and decode block, and the bind
// that attaches them to the top level. Depends on tpdd_pkg.
module tpdd_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [15:0] i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_raw_position_lines,
    input logic        i_raw_parity_a,
    input logic        i_raw_parity_b,
    input logic        i_raw_polarity,
    input logic        i_raw_motor_select,
    input logic        i_raw_solenoid,
    input logic [4:0]  i_stored_position,
    input logic [7:0]  i_solenoid_fault_count,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [4:0]  o_tap_position,
    input logic [1:0]  o_position_status,
    input logic [16:0] o_position_flags,
    input logic [3:0]  o_selected_line,
    input logic        o_motor_select_seen,
    input logic        o_solenoid_seen,
    input logic        o_check_status
);
    import tpdd_pkg::*;

    // A result that waits on the consumer stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_tap_position)
            && $stable(o_position_status) && $stable(o_position_flags)
            && $stable(o_check_status))
        else $error("result transaction changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_tap_vs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_position_status == ST_OK) == (o_tap_position != 5'd0)))
        else $error("tap position disagrees with status");

    a_onehot_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_position_status == ST_OK |-> $onehot0(o_position_flags))
        else $error("position flags not one-hot for a decoded tap");

endmodule

bind tap_position_debounce_decode tpdd_props u_tpdd_props (.*);

// ----- verif/tpdd_checker.sv -----
// Checker for the tap position debounce and decode block: follows the contact-pin
// debounce, position decode and fault marks, and compares every result transaction.
// Depends on tpdd_pkg for widths, line positions and status codes.
`timescale 1ns / 100ps

module tpdd_checker #(
    parameter int NUM_POSITIONS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_raw_position_lines,
    input  logic        i_raw_parity_a,
    input  logic        i_raw_parity_b,
    input  logic        i_raw_polarity,
    input  logic        i_raw_motor_select,
    input  logic        i_raw_solenoid,
    input  logic [4:0]  i_stored_position,
    input  logic [7:0]  i_solenoid_fault_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [4:0]  i_tap_position,
    input  logic [1:0]  i_position_status,
    input  logic [16:0] i_position_flags,
    input  logic [3:0]  i_selected_line,
    input  logic        i_motor_select_seen,
    input  logic        i_solenoid_seen,
    input  logic        i_check_status,
    output int          o_pending,
    output int          o_failures
);
    import tpdd_pkg::*;

    typedef struct packed {
        logic [TAP_W-1:0]      tap;
        logic [STATUS_W-1:0]   status;
        logic [FLAG_W-1:0]     flags;
        logic [LINE_IDX_W-1:0] line;
        logic                  motor;
        logic                  solenoid;
        logic                  check;
    } t_tap_reading;

    logic [CNT_W-1:0]         debounce_ticks;
    logic [CNT_W-1:0]         line_cnt [NUM_LINES];
    logic [NUM_LINES-1:0]     deb_lines;
    logic [NUM_POSITIONS:0]   fault_marks;
    logic [LINE_IDX_W-1:0]    last_line;
    t_tap_reading             expected_readings [$];
    int                       failures = 0;

    // One sampling tick: counters and debounced lines first, then the decode
    // works on the new debounced lines.
    task automatic sample_and_decode(input logic [NUM_LINES-1:0] pins,
                                     input logic [SP_W-1:0] sp,
                                     input logic [FAULT_CNT_W-1:0] fault_cnt,
                                     output t_tap_reading r);
        int i;
        int n_active;
        int k;
        int m;
        int tap_val;
        logic pa;
        logic pb;
        logic pol;
        logic ok;
        logic lock;

        n_active = 0;
        k = 0;
        tap_val = 0;
        ok = 1'b0;
        r = '0;

        // A pin is active low, so a pin equal to its debounced bit disagrees with it.
        for (i = 0; i < NUM_LINES; i++) begin
            if (pins[i] == deb_lines[i]) begin
                if (line_cnt[i] < debounce_ticks) begin
                    line_cnt[i] = line_cnt[i] + CNT_W'(1);
                end else begin
                    deb_lines[i] = ~pins[i];
                end
            end else begin
                line_cnt[i] = '0;
            end
        end

        for (i = 0; i < NUM_POS_LINES; i++) begin
            if (deb_lines[i]) begin
                n_active++;
                k = i + 1;
            end
        end
        pa  = deb_lines[LN_PARITY_A];
        pb  = deb_lines[LN_PARITY_B];
        pol = deb_lines[LN_POLARITY];

        if (n_active == 1 && pa != pb) begin
            m = k;
            if (pa) begin
                m = m & ~1;
            end else if (m % 2 == 0) begin
                m = m - 1;
            end
            tap_val = pol ? int'(CENTER_POS) + m : int'(CENTER_POS) - m;
            ok = 1'b1;
            r.status = ST_OK;
        end else if (n_active == 0 || (n_active == 1 && !pa && !pb)) begin
            r.status = ST_NONE;
        end else begin
            r.status = ST_SEVERAL;
        end

        lock = fault_cnt > LOCKOUT_LIMIT;
        if (!lock) begin
            if (ok) begin
                last_line = LINE_IDX_W'(k);
            end
            if (sp <= NUM_POSITIONS) begin
                fault_marks[sp] = !ok;
            end
        end

        if (ok) begin
            r.tap = TAP_W'(tap_val);
            if (tap_val >= 1 && tap_val <= NUM_POSITIONS && tap_val <= FLAG_W) begin
                r.flags[tap_val-1] = 1'b1;
            end
        end else begin
            r.flags = FLAG_W'(deb_lines[NUM_CONTACTS-1:0]);
        end

        r.line     = last_line;
        r.motor    = deb_lines[LN_MOTOR_SEL];
        r.solenoid = deb_lines[LN_SOLENOID];
        r.check    = lock;
        // Mark 0 can be set but never raises the check flag.
        for (i = 1; i <= NUM_POSITIONS; i++) begin
            if (fault_marks[i]) begin
                r.check = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_tap_reading want;
        t_tap_reading got;
        int i;

        if (!i_rst_n) begin
            debounce_ticks = TICKS_RESET;
            for (i = 0; i < NUM_LINES; i++) begin
                line_cnt[i] = CNT_RESET;
            end
            deb_lines   = '0;
            fault_marks = '0;
            last_line   = '0;
            expected_readings.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.tap      = i_tap_position;
                got.status   = i_position_status;
                got.flags    = i_position_flags;
                got.line     = i_selected_line;
                got.motor    = i_motor_select_seen;
                got.solenoid = i_solenoid_seen;
                got.check    = i_check_status;
                if (expected_readings.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("%0t: result transaction with nothing expected: tap %0d status %0d",
                                 $realtime, got.tap, got.status);
                    end
                end else begin
                    want = expected_readings.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10) begin
                            $write("%0t: mismatch (expected/actual) tap %0d/%0d status %0d/%0d ",
                                   $realtime, want.tap, got.tap, want.status, got.status);
                            $write("flags %h/%h line %0d/%0d ",
                                   want.flags, got.flags, want.line, got.line);
                            $display("motor %b/%b solenoid %b/%b check %b/%b",
                                     want.motor, got.motor, want.solenoid, got.solenoid,
                                     want.check, got.check);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                sample_and_decode({i_raw_solenoid, i_raw_motor_select, i_raw_polarity,
                                   i_raw_parity_b, i_raw_parity_a, i_raw_position_lines},
                                  i_stored_position, i_solenoid_fault_count, want);
                expected_readings.push_back(want);
            end

            if (i_cfg_we) begin
                debounce_ticks = i_cfg_data;
            end
        end
        o_pending  <= expected_readings.size();
        o_failures <= failures;
    end

endmodule

// ----- verif/tb_tap_position_debounce_decode.sv -----
// Testbench top for tap_position_debounce_decode: drives contact-pin transactions and
// debounce settings, stalls the result side, and reports the verdict from tpdd_checker.
// Depends on tpdd_pkg, the block's RTL and verif/tpdd_checker.sv.
`timescale 1ns / 100ps

module tb_tap_position_debounce_decode;
    import tpdd_pkg::*;

    localparam int NUM_POSITIONS = 17;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 8;

    typedef logic [NUM_LINES-1:0] t_pins;

    localparam t_pins ACT_PA  = t_pins'(1) << LN_PARITY_A;
    localparam t_pins ACT_PB  = t_pins'(1) << LN_PARITY_B;
    localparam t_pins ACT_POL = t_pins'(1) << LN_POLARITY;
    localparam t_pins ACT_MS  = t_pins'(1) << LN_MOTOR_SEL;
    localparam t_pins ACT_SOL = t_pins'(1) << LN_SOLENOID;

    typedef enum int {SHAPE_DECODE, SHAPE_NONE, SHAPE_SEVERAL, SHAPE_NOISE} t_pin_shape;
    typedef enum int {STALL_NEVER, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_kind;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    t_pins       pins;
    logic [4:0]  stored_pos;
    logic [7:0]  fault_cnt;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  tap_position;
    logic [1:0]  position_status;
    logic [16:0] position_flags;
    logic [3:0]  selected_line;
    logic        motor_select_seen;
    logic        solenoid_seen;
    logic        check_status;
    int          pending;
    int          failures;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          cur_ticks = int'(TICKS_RESET);

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    tap_position_debounce_decode #(
        .NUM_POSITIONS(NUM_POSITIONS)
    ) uut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_raw_position_lines   (pins[NUM_POS_LINES-1:0]),
        .i_raw_parity_a         (pins[LN_PARITY_A]),
        .i_raw_parity_b         (pins[LN_PARITY_B]),
        .i_raw_polarity         (pins[LN_POLARITY]),
        .i_raw_motor_select     (pins[LN_MOTOR_SEL]),
        .i_raw_solenoid         (pins[LN_SOLENOID]),
        .i_stored_position      (stored_pos),
        .i_solenoid_fault_count (fault_cnt),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_tap_position         (tap_position),
        .o_position_status      (position_status),
        .o_position_flags       (position_flags),
        .o_selected_line        (selected_line),
        .o_motor_select_seen    (motor_select_seen),
        .o_solenoid_seen        (solenoid_seen),
        .o_check_status         (check_status)
    );

    tpdd_checker #(
        .NUM_POSITIONS(NUM_POSITIONS)
    ) u_checker (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .i_in_stall             (in_stall),
        .i_raw_position_lines   (pins[NUM_POS_LINES-1:0]),
        .i_raw_parity_a         (pins[LN_PARITY_A]),
        .i_raw_parity_b         (pins[LN_PARITY_B]),
        .i_raw_polarity         (pins[LN_POLARITY]),
        .i_raw_motor_select     (pins[LN_MOTOR_SEL]),
        .i_raw_solenoid         (pins[LN_SOLENOID]),
        .i_stored_position      (stored_pos),
        .i_solenoid_fault_count (fault_cnt),
        .i_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .i_tap_position         (tap_position),
        .i_position_status      (position_status),
        .i_position_flags       (position_flags),
        .i_selected_line        (selected_line),
        .i_motor_select_seen    (motor_select_seen),
        .i_solenoid_seen        (solenoid_seen),
        .i_check_status         (check_status),
        .o_pending              (pending),
        .o_failures             (failures)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_tap_position_debounce_decode: done, errors");
            $finish;
        end
    end

    // The result side stalls in segments, each with a stall pattern of its own.
    initial begin
        t_stall_kind kind;
        int seg;
        int i;

        out_stall = 1'b0;
        forever begin
            kind = t_stall_kind'($urandom_range(0, 3));
            seg  = $urandom_range(20, 150);
            for (i = 0; i < seg; i++) begin
                @(negedge clk);
                case (kind)
                    STALL_NEVER:    out_stall = 1'b0;
                    STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
                    default:        out_stall = (i % 5) >= 3;
                endcase
            end
        end
    end

    function automatic t_pins pos_line(input int k);
        return t_pins'(1) << (k - 1);
    endfunction

    // Builds a pin pattern (active low) of the requested shape.
    function automatic t_pins pick_pins(input t_pin_shape shape);
        t_pins act;
        logic [NUM_POS_LINES-1:0] lines;

        act = t_pins'($urandom);
        lines = '0;
        case (shape)
            SHAPE_DECODE: begin
                lines[$urandom_range(0, NUM_POS_LINES-1)] = 1'b1;
                act[LN_PARITY_A] = 1'($urandom_range(0, 1));
                act[LN_PARITY_B] = ~act[LN_PARITY_A];
            end
            SHAPE_NONE: begin
                if ($urandom_range(0, 1)) begin
                    lines[$urandom_range(0, NUM_POS_LINES-1)] = 1'b1;
                    act[LN_PARITY_A] = 1'b0;
                    act[LN_PARITY_B] = 1'b0;
                end
            end
            SHAPE_SEVERAL: begin
                if ($urandom_range(0, 1)) begin
                    do begin
                        lines = NUM_POS_LINES'($urandom);
                    end while ($countones(lines) < 2);
                end else begin
                    lines[$urandom_range(0, NUM_POS_LINES-1)] = 1'b1;
                    act[LN_PARITY_A] = 1'b1;
                    act[LN_PARITY_B] = 1'b1;
                end
            end
            default: begin
                lines = act[NUM_POS_LINES-1:0];
            end
        endcase
        act[NUM_POS_LINES-1:0] = lines;
        return ~act;
    endfunction

    task automatic gap(input int n);
        repeat (n) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // Sends one input transaction; the sender works in bursts with random gaps.
    task automatic send(input t_pins p, input logic [4:0] sp, input logic [7:0] fc);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) begin
                gap($urandom_range(1, 8));
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid   = 1'b1;
        pins       = p;
        stored_pos = sp;
        fault_cnt  = fc;
        do begin
            @(posedge clk);
        end while (in_stall);
    endtask

    // Debounce time changes only with the block drained and quiet.
    task automatic configure(input logic [15:0] ticks);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = ticks;
        @(negedge clk);
        cfg_we   = 1'b0;
        cur_ticks = int'(ticks);
    endtask

    // Mostly patterns held long enough to pass the debounce, with glitches and
    // some patterns dropped too early; above 64 debounce ticks every pattern is dropped early.
    task automatic run_phase(input int n_items);
        int sent;
        int hold;
        int h;
        int roll;
        t_pin_shape shape;
        t_pins held;
        t_pins now_pins;
        logic [4:0] sp;
        logic [7:0] fc;

        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                shape = SHAPE_DECODE;
            end else if (roll < 72) begin
                shape = SHAPE_NONE;
            end else if (roll < 84) begin
                shape = SHAPE_SEVERAL;
            end else begin
                shape = SHAPE_NOISE;
            end
            held = pick_pins(shape);
            if (cur_ticks > 64) begin
                hold = $urandom_range(1, 8);
            end else if ($urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, cur_ticks + 1);
            end else begin
                hold = cur_ticks + 1 + $urandom_range(0, 6);
            end
            for (h = 0; h < hold; h++) begin
                now_pins = held;
                if ($urandom_range(0, 24) == 0) begin
                    now_pins[$urandom_range(0, NUM_LINES-1)] ^= 1'b1;
                end
                sp = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(NUM_POSITIONS + 1, 31))
                                                 : 5'($urandom_range(0, NUM_POSITIONS));
                roll = $urandom_range(0, 99);
                if (roll < 75) begin
                    fc = 8'($urandom_range(0, int'(LOCKOUT_LIMIT)));
                end else if (roll < 90) begin
                    fc = 8'($urandom_range(int'(LOCKOUT_LIMIT) + 1, 255));
                end else begin
                    fc = 8'($urandom);
                end
                send(now_pins, sp, fc);
                sent++;
            end
        end
    endtask

    initial begin
        int k;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        pins       = '1;
        stored_pos = '0;
        fault_cnt  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // With no debounce delay every transaction takes effect at once.
        configure(16'd0);
        send(~t_pins'(0), 5'd5, 8'd0);
        send(~(pos_line(1) | ACT_PA), 5'd5, 8'd0);
        send(~(pos_line(8) | ACT_PA | ACT_POL), 5'd17, 8'd0);
        send(~(pos_line(8) | ACT_PB), 5'd0, 8'd0);
        send(~(pos_line(1) | ACT_PB | ACT_POL), 5'd1, 8'd0);
        send(~(pos_line(8) | ACT_PA), 5'd2, 8'd0);
        send(~(pos_line(3) | ACT_PA | ACT_PB), 5'd17, 8'd0);
        send(~pos_line(3), 5'd18, 8'd0);
        send(~(pos_line(2) | pos_line(6) | ACT_PB), 5'd31, 8'd3);
        send(~(pos_line(4) | ACT_PB | ACT_POL), 5'd17, 8'd255);
        send(~(pos_line(4) | ACT_PB | ACT_POL), 5'd17, 8'd2);
        send(~t_pins'('1), 5'd0, 8'd1);
        send(~(pos_line(5) | ACT_PA | ACT_MS | ACT_SOL), 5'd9, 8'd0);
        send(~t_pins'(0), 5'd0, 8'd0);
        for (k = 1; k <= NUM_POS_LINES; k++) begin
            send(~(pos_line(k) | ((k % 2 == 1) ? ACT_PB : ACT_PA) | ((k <= 4) ? ACT_POL : '0)),
                 5'(k), 8'd0);
        end

        configure(16'd3);
        run_phase(200);
        configure(TICKS_RESET);
        run_phase(200);
        configure(16'd1);
        run_phase(150);
        configure(16'hffff);
        run_phase(40);
        configure(16'd0);
        run_phase(150);
        configure(16'd6);
        run_phase(160);
        configure(16'd2);
        run_phase(100);

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0) begin
            $display("tb_tap_position_debounce_decode: done, clean");
        end else begin
            $display("tb_tap_position_debounce_decode: done, errors");
        end
        $finish;
    end

endmodule
